>>> sv/mpk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MessagePack token decoder.
// No dependencies; used by mpk_step and msgpack_token_decoder_top.
package mpk_pkg;

  typedef enum logic [3:0] {
    KIND_NIL     = 4'd0,
    KIND_BOOL    = 4'd1,
    KIND_UINT    = 4'd2,
    KIND_INT     = 4'd3,
    KIND_F32     = 4'd4,
    KIND_F64     = 4'd5,
    KIND_STR     = 4'd6,
    KIND_BIN     = 4'd7,
    KIND_EXT     = 4'd8,
    KIND_ARRAY   = 4'd9,
    KIND_MAP     = 4'd10,
    KIND_PAYLOAD = 4'd11,
    KIND_ERROR   = 4'd12
  } token_kind_e;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_FIELD   = 2'd1;
  localparam logic [1:0] PH_EXTCODE = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam int unsigned ValueWidth = 64;

  typedef struct packed {
    logic [1:0]            phase;
    logic [3:0]            bytes_left;
    logic                  field_first;
    token_kind_e           pending_kind;
    logic [ValueWidth-1:0] acc;
  } dec_state_t;

  typedef struct packed {
    token_kind_e           kind;
    logic [ValueWidth-1:0] value;
    logic signed [7:0]     ext_code;
    logic                  last;
  } token_t;

endpackage

>>> sv/mpk_step.sv
`timescale 1ns / 1ps
// Next-state and token logic for one byte of the MessagePack stream.
// Depends on mpk_pkg; instantiated by msgpack_token_decoder_top.
module mpk_step #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  mpk_pkg::dec_state_t     cur_i,
  input  logic [LENGTH_WIDTH-1:0] rem_i,
  input  logic [7:0]              byte_i,
  output mpk_pkg::dec_state_t     nxt_o,
  output logic [LENGTH_WIDTH-1:0] rem_o,
  output logic                    emit_o,
  output mpk_pkg::token_t         tok_o
);
  import mpk_pkg::*;

  logic [ValueWidth-1:0]   acc_base;
  logic [ValueWidth-1:0]   acc_new;
  logic                    too_big;
  logic [LENGTH_WIDTH-1:0] rem_dec;
  logic [7:0]              off;
  logic [4:0]              fix_len;

  assign acc_base = (cur_i.field_first && (cur_i.pending_kind == KIND_INT) && byte_i[7])
                    ? {ValueWidth{1'b1}} : cur_i.acc;
  assign acc_new  = {acc_base[ValueWidth-9:0], byte_i};
  assign too_big  = |acc_new[ValueWidth-1:LENGTH_WIDTH];
  assign rem_dec  = (rem_i == '0) ? '0 : rem_i - LENGTH_WIDTH'(1);

  always_comb begin
    nxt_o   = cur_i;
    rem_o   = rem_i;
    emit_o  = 1'b0;
    tok_o   = '{kind: KIND_NIL, value: '0, ext_code: '0, last: 1'b0};
    off     = 8'd0;
    fix_len = 5'd0;
    unique case (cur_i.phase)
      PH_IDLE: begin
        priority if (byte_i <= 8'h7F) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_UINT;
          tok_o.value = {56'd0, byte_i};
        end else if (byte_i <= 8'h8F) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_MAP;
          tok_o.value = {60'd0, byte_i[3:0]};
        end else if (byte_i <= 8'h9F) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_ARRAY;
          tok_o.value = {60'd0, byte_i[3:0]};
        end else if (byte_i <= 8'hBF) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_STR;
          tok_o.value = {59'd0, byte_i[4:0]};
          if (byte_i[4:0] != 5'd0) begin
            rem_o = LENGTH_WIDTH'(byte_i[4:0]);
            nxt_o.phase = PH_PAYLOAD;
          end
        end else if (byte_i >= 8'hE0) begin
          emit_o = 1'b1;
          tok_o.kind = KIND_INT;
          tok_o.value = {{56{1'b1}}, byte_i};
        end else begin
          nxt_o.field_first = 1'b1;
          nxt_o.acc = '0;
          unique case (byte_i)
            8'hC0: begin
              emit_o = 1'b1;
              tok_o.kind = KIND_NIL;
            end
            8'hC1: begin
              emit_o = 1'b1;
              tok_o.kind = KIND_ERROR;
            end
            8'hC2, 8'hC3: begin
              emit_o = 1'b1;
              tok_o.kind = KIND_BOOL;
              tok_o.value = {63'd0, byte_i[0]};
            end
            8'hC4, 8'hC5, 8'hC6: begin
              off = byte_i - 8'hC4;
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_BIN;
              nxt_o.bytes_left = 4'd1 << off[1:0];
            end
            8'hC7, 8'hC8, 8'hC9: begin
              off = byte_i - 8'hC7;
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_EXT;
              nxt_o.bytes_left = 4'd1 << off[1:0];
            end
            8'hCA: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_F32;
              nxt_o.bytes_left = 4'd4;
            end
            8'hCB: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_F64;
              nxt_o.bytes_left = 4'd8;
            end
            8'hCC, 8'hCD, 8'hCE, 8'hCF: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_UINT;
              nxt_o.bytes_left = 4'd1 << byte_i[1:0];
            end
            8'hD0, 8'hD1, 8'hD2, 8'hD3: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_INT;
              nxt_o.bytes_left = 4'd1 << byte_i[1:0];
            end
            8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8: begin
              off = byte_i - 8'hD4;
              fix_len = 5'd1 << off[2:0];
              rem_o = LENGTH_WIDTH'(fix_len);
              nxt_o.phase = PH_EXTCODE;
            end
            8'hD9, 8'hDA, 8'hDB: begin
              off = byte_i - 8'hD9;
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_STR;
              nxt_o.bytes_left = 4'd1 << off[1:0];
            end
            8'hDC: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_ARRAY;
              nxt_o.bytes_left = 4'd2;
            end
            8'hDD: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_ARRAY;
              nxt_o.bytes_left = 4'd4;
            end
            8'hDE: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_MAP;
              nxt_o.bytes_left = 4'd2;
            end
            default: begin
              nxt_o.phase = PH_FIELD;
              nxt_o.pending_kind = KIND_MAP;
              nxt_o.bytes_left = 4'd4;
            end
          endcase
        end
      end
      PH_FIELD: begin
        nxt_o.acc = acc_new;
        nxt_o.field_first = 1'b0;
        nxt_o.bytes_left = cur_i.bytes_left - 4'd1;
        if (cur_i.bytes_left == 4'd1) begin
          nxt_o.phase = PH_IDLE;
          priority if (cur_i.pending_kind == KIND_STR || cur_i.pending_kind == KIND_BIN) begin
            emit_o = 1'b1;
            if (too_big) begin
              tok_o.kind = KIND_ERROR;
            end else begin
              tok_o.kind = cur_i.pending_kind;
              tok_o.value = acc_new;
              if (acc_new[LENGTH_WIDTH-1:0] != '0) begin
                rem_o = acc_new[LENGTH_WIDTH-1:0];
                nxt_o.phase = PH_PAYLOAD;
              end
            end
          end else if (cur_i.pending_kind == KIND_EXT) begin
            if (too_big) begin
              emit_o = 1'b1;
              tok_o.kind = KIND_ERROR;
            end else begin
              rem_o = acc_new[LENGTH_WIDTH-1:0];
              nxt_o.phase = PH_EXTCODE;
            end
          end else begin
            emit_o = 1'b1;
            tok_o.kind = cur_i.pending_kind;
            tok_o.value = acc_new;
          end
        end
      end
      PH_EXTCODE: begin
        emit_o = 1'b1;
        tok_o.kind = KIND_EXT;
        tok_o.value = {{(ValueWidth-LENGTH_WIDTH){1'b0}}, rem_i};
        tok_o.ext_code = byte_i;
        nxt_o.phase = (rem_i != '0) ? PH_PAYLOAD : PH_IDLE;
      end
      default: begin
        emit_o = 1'b1;
        tok_o.kind = KIND_PAYLOAD;
        tok_o.value = {56'd0, byte_i};
        tok_o.last = (rem_i <= LENGTH_WIDTH'(1));
        rem_o = rem_dec;
        if (rem_dec == '0) begin
          nxt_o.phase = PH_IDLE;
        end
      end
    endcase
  end

endmodule

>>> sv/msgpack_token_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the MessagePack token decoder: stream ports, state and token registers.
// Depends on mpk_pkg and mpk_step.
//
// The slave stream takes one MessagePack byte per transfer on s_axis_tdata_i.
// The master stream gives one flat token per transfer: the kind on m_axis_tuser_o,
// the value and ext type code on m_axis_tdata_o, and tlast set on the final
// payload byte of a str, bin or ext. A format byte that opens a length or value
// field, the bytes of such a field before its last, the whole length field of an
// ext and the format byte of a fixext give no token.
// A byte is decoded in the cycle it is accepted and its token, if any, appears
// on the master side in the next cycle. One byte is taken every cycle while the
// token register is empty or being taken in the same cycle, so a ready receiver
// sees a sustained rate of one byte per clock; the single token register sets
// that figure. When the receiver stalls with a token held, s_axis_tready_o drops
// until the token is taken, and the held token stays unchanged.
// Reset returns the decoder to waiting for a type byte and empties the token
// register; a message cut by reset is dropped.
module msgpack_token_decoder_top #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] token_value, [71:64] ext_code
  output logic [3:0]  m_axis_tuser_o,   // [3:0] token_kind
  output logic        m_axis_tlast_o    // last_payload
);
  import mpk_pkg::*;

  dec_state_t              state_q, state_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic                    valid_q;
  token_t                  tok_q, tok_d;
  logic                    emit;
  logic                    in_fire;

  mpk_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .cur_i (state_q),
    .rem_i (rem_q),
    .byte_i(s_axis_tdata_i),
    .nxt_o (state_d),
    .rem_o (rem_d),
    .emit_o(emit),
    .tok_o (tok_d)
  );

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, bytes_left: 4'd0, field_first: 1'b0,
                   pending_kind: KIND_NIL, acc: '0};
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
        rem_q   <= rem_d;
        valid_q <= emit;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      tok_q <= tok_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {tok_q.ext_code, tok_q.value};
  assign m_axis_tuser_o  = tok_q.kind;
  assign m_axis_tlast_o  = tok_q.last;

endmodule
